// ----- hdl/shst_pkg.sv -----
// Shared constants, codes and control types of the symbol histogram table.
`timescale 1ns / 1ps
package shst_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int COUNT_BITS   = 32;
    localparam int SYM_W        = $clog2(SYMBOL_COUNT);
    localparam int CNT_W        = $clog2(SYMBOL_COUNT + 1);
    localparam int BYTE_W       = 8;
    localparam int FREQ_W       = 32;
    localparam int DIST_W       = 9;
    localparam int MODE_W       = 2;

    // Counters stop here, so a count plus the tie adjustment never wraps.
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1 - COUNT_BITS'(256);

    typedef enum logic [MODE_W-1:0] {
        MODE_COUNT    = 2'd0,
        MODE_FINALIZE = 2'd1,
        MODE_READ     = 2'd2,
        MODE_CLEAR    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HIST_RD_BYTE,
        OP_HIST_WR_INC,
        OP_HIST_CLEAR,
        OP_HIST_RD_SYM,
        OP_LATCH_SYM,
        OP_SCAN,
        OP_PLACE,
        OP_BUMP_INIT,
        OP_TAB_RD_BUMP,
        OP_TAB_WR_BUMP,
        OP_TAB_RD_IDX
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
        logic out_read;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic t_last;
        logic s_last;
        logic i_last;
        logic n_zero;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [BYTE_W-1:0]     sym;
        logic [COUNT_BITS-1:0] freq;
    } t_entry;

endpackage

// ----- hdl/shst_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
interface shst_in_if;
    logic                        valid;
    logic                        ready;
    logic [shst_pkg::MODE_W-1:0] mode;
    logic [shst_pkg::BYTE_W-1:0] data_byte;
    logic [shst_pkg::BYTE_W-1:0] entry_index;

    modport source (output valid, mode, data_byte, entry_index, input ready);
    modport sink (input valid, mode, data_byte, entry_index, output ready);
endinterface

interface shst_out_if;
    logic                        valid;
    logic                        ready;
    logic [shst_pkg::BYTE_W-1:0] symbol;
    logic [shst_pkg::FREQ_W-1:0] frequency;
    logic                        entry_valid;
    logic [shst_pkg::DIST_W-1:0] distinct_count;

    modport source (output valid, symbol, frequency, entry_valid, distinct_count,
                    input ready);
    modport sink (input valid, symbol, frequency, entry_valid, distinct_count,
                  output ready);
endinterface

// ----- hdl/shst_ctrl.sv -----
// Sequencer for counting, table build, table reads and clearing.
`timescale 1ns / 1ps
module shst_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [shst_pkg::MODE_W-1:0] i_mode,
    input  shst_pkg::t_dp_status   i_status,
    output logic                   o_idle,
    output shst_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_CLR, ST_RD_RD, ST_RD_OUT,
        ST_F_SRD, ST_F_HS, ST_F_SCAN, ST_F_DRAIN, ST_F_PLACE,
        ST_B_INIT, ST_B_RD, ST_B_WR, ST_F_DONE
    } t_state;

    t_state              r_state, n_state;
    shst_pkg::t_ctrl_cmd r_cmd, n_cmd;

    // Next state and the command for the following cycle.
    always_comb begin
        n_state = r_state;
        n_cmd   = '{op: shst_pkg::OP_NONE, load_out: 1'b0, out_read: 1'b0,
                    commit: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (shst_pkg::t_mode'(i_mode))
                        shst_pkg::MODE_COUNT: begin
                            n_state  = ST_CNT_RD;
                            n_cmd.op = shst_pkg::OP_HIST_RD_BYTE;
                        end
                        shst_pkg::MODE_FINALIZE: begin
                            n_state  = ST_F_SRD;
                            n_cmd.op = shst_pkg::OP_HIST_RD_SYM;
                        end
                        shst_pkg::MODE_READ: begin
                            n_state  = ST_RD_RD;
                            n_cmd.op = shst_pkg::OP_TAB_RD_IDX;
                        end
                        default: begin
                            n_state        = ST_CLR;
                            n_cmd.op       = shst_pkg::OP_HIST_CLEAR;
                            n_cmd.load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_CNT_RD: begin
                n_state        = ST_CNT_WR;
                n_cmd.op       = shst_pkg::OP_HIST_WR_INC;
                n_cmd.load_out = 1'b1;
            end
            ST_RD_RD: begin
                n_state        = ST_RD_OUT;
                n_cmd.load_out = 1'b1;
                n_cmd.out_read = 1'b1;
            end
            ST_F_SRD: begin
                n_state  = ST_F_HS;
                n_cmd.op = shst_pkg::OP_LATCH_SYM;
            end
            ST_F_HS: begin
                n_state  = ST_F_SCAN;
                n_cmd.op = shst_pkg::OP_SCAN;
            end
            ST_F_SCAN: begin
                if (i_status.t_last) begin
                    n_state = ST_F_DRAIN;
                end else begin
                    n_cmd.op = shst_pkg::OP_SCAN;
                end
            end
            ST_F_DRAIN: begin
                n_state  = ST_F_PLACE;
                n_cmd.op = shst_pkg::OP_PLACE;
            end
            ST_F_PLACE: begin
                if (i_status.s_last) begin
                    n_state  = ST_B_INIT;
                    n_cmd.op = shst_pkg::OP_BUMP_INIT;
                end else begin
                    n_state  = ST_F_SRD;
                    n_cmd.op = shst_pkg::OP_HIST_RD_SYM;
                end
            end
            ST_B_INIT: begin
                if (i_status.n_zero) begin
                    n_state        = ST_F_DONE;
                    n_cmd.load_out = 1'b1;
                    n_cmd.commit   = 1'b1;
                end else begin
                    n_state  = ST_B_RD;
                    n_cmd.op = shst_pkg::OP_TAB_RD_BUMP;
                end
            end
            ST_B_RD: begin
                n_state  = ST_B_WR;
                n_cmd.op = shst_pkg::OP_TAB_WR_BUMP;
            end
            ST_B_WR: begin
                if (i_status.i_last) begin
                    n_state        = ST_F_DONE;
                    n_cmd.load_out = 1'b1;
                    n_cmd.commit   = 1'b1;
                end else begin
                    n_state  = ST_B_RD;
                    n_cmd.op = shst_pkg::OP_TAB_RD_BUMP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= '{op: shst_pkg::OP_NONE, load_out: 1'b0, out_read: 1'b0,
                         commit: 1'b0};
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    assign o_cmd  = r_cmd;
    assign o_idle = (r_state == ST_IDLE) && i_status.out_free;

endmodule

// ----- hdl/shst_dp.sv -----
// Histogram and table memories, build counters and the result register.
`timescale 1ns / 1ps
module shst_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [shst_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [shst_pkg::BYTE_W-1:0] i_entry_index,
    input  shst_pkg::t_ctrl_cmd         i_cmd,
    output shst_pkg::t_dp_status        o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [shst_pkg::BYTE_W-1:0] o_symbol,
    output logic [shst_pkg::FREQ_W-1:0] o_frequency,
    output logic                        o_entry_valid,
    output logic [shst_pkg::DIST_W-1:0] o_distinct_count
);

    logic [shst_pkg::COUNT_BITS-1:0] r_hist [shst_pkg::SYMBOL_COUNT];
    logic [shst_pkg::SYMBOL_COUNT-1:0] r_hvld;
    shst_pkg::t_entry                r_tab [shst_pkg::SYMBOL_COUNT];

    logic [shst_pkg::COUNT_BITS-1:0] r_hrd;
    shst_pkg::t_entry                r_trd;
    logic [shst_pkg::BYTE_W-1:0]     r_byte, r_idx;
    logic [shst_pkg::SYM_W-1:0]      r_s, r_t, r_tq;
    logic [shst_pkg::SYM_W-1:0]      r_i;
    logic [shst_pkg::COUNT_BITS-1:0] r_hs, r_prev;
    logic [shst_pkg::CNT_W-1:0]      r_rank, r_n, r_bump, r_len, n_bump;
    logic                            r_scan_v, r_ovalid;
    logic [shst_pkg::BYTE_W-1:0]     r_osym;
    logic [shst_pkg::FREQ_W-1:0]     r_ofreq;
    logic                            r_oev;
    logic [shst_pkg::DIST_W-1:0]     r_odist;

    logic [shst_pkg::SYM_W-1:0]      byte_addr, idx_addr, hist_addr;
    logic [shst_pkg::COUNT_BITS-1:0] inc_val, orig;
    logic                            byte_ok, earlier, rd_ok;

    assign byte_addr = r_byte[shst_pkg::SYM_W-1:0];
    assign idx_addr  = r_idx[shst_pkg::SYM_W-1:0];
    assign byte_ok   = 32'(r_byte) < 32'(shst_pkg::SYMBOL_COUNT);
    assign hist_addr = (i_cmd.op == shst_pkg::OP_HIST_RD_BYTE) ? byte_addr :
                       (i_cmd.op == shst_pkg::OP_SCAN) ? r_t : r_s;
    assign inc_val   = (r_hrd < shst_pkg::COUNT_MAX) ? r_hrd + 1'b1 : r_hrd;

    // A scanned symbol sorts ahead of the current one.
    assign earlier = (r_hrd != '0) &&
                     ((r_hrd < r_hs) || ((r_hrd == r_hs) && (r_tq < r_s)));

    // Tie adjustment for the table walk.
    assign orig   = r_trd.freq;
    assign n_bump = ((r_i != '0) && (r_prev == orig)) ? r_bump + 1'b1 : r_bump;
    assign rd_ok  = 32'(r_idx) < 32'(r_len);

    // Histogram memory; a symbol without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        r_hrd <= r_hvld[hist_addr] ? r_hist[hist_addr] : '0;
        if (i_cmd.op == shst_pkg::OP_HIST_WR_INC && byte_ok) begin
            r_hist[byte_addr] <= inc_val;
        end
    end

    // Table memory.
    always_ff @(posedge i_clk) begin
        r_trd <= r_tab[(i_cmd.op == shst_pkg::OP_TAB_RD_IDX) ? idx_addr : r_i];
        if (i_cmd.op == shst_pkg::OP_PLACE && r_hs != '0) begin
            r_tab[r_rank[shst_pkg::SYM_W-1:0]] <= '{sym: shst_pkg::BYTE_W'(r_s),
                                                    freq: r_hs};
        end else if (i_cmd.op == shst_pkg::OP_TAB_WR_BUMP) begin
            r_tab[r_i] <= '{sym: r_trd.sym,
                            freq: orig + shst_pkg::COUNT_BITS'(n_bump)};
        end
    end

    // Build counters and latched item fields.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byte <= i_data_byte;
            r_idx  <= i_entry_index;
            r_s    <= '0;
            r_n    <= '0;
        end
        r_tq <= r_t;
        case (i_cmd.op)
            shst_pkg::OP_HIST_RD_SYM: begin
                r_t    <= '0;
                r_rank <= '0;
            end
            shst_pkg::OP_LATCH_SYM: begin
                r_hs <= r_hrd;
            end
            shst_pkg::OP_SCAN: begin
                r_t <= r_t + 1'b1;
            end
            shst_pkg::OP_PLACE: begin
                r_s <= r_s + 1'b1;
                if (r_hs != '0) begin
                    r_n <= r_n + 1'b1;
                end
            end
            shst_pkg::OP_BUMP_INIT: begin
                r_i    <= '0;
                r_bump <= '0;
            end
            shst_pkg::OP_TAB_WR_BUMP: begin
                r_bump <= n_bump;
                r_prev <= orig;
                r_i    <= r_i + 1'b1;
            end
            default: begin
            end
        endcase
        if (r_scan_v && earlier) begin
            r_rank <= r_rank + 1'b1;
        end
    end

    // Control flags, valid bits and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld   <= '0;
            r_len    <= '0;
            r_scan_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_scan_v <= (i_cmd.op == shst_pkg::OP_SCAN);
            if (i_cmd.op == shst_pkg::OP_HIST_CLEAR) begin
                r_hvld <= '0;
            end else if (i_cmd.op == shst_pkg::OP_HIST_WR_INC && byte_ok) begin
                r_hvld[byte_addr] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_len <= r_n;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_odist <= shst_pkg::DIST_W'(i_cmd.commit ? r_n : r_len);
            if (i_cmd.out_read && rd_ok) begin
                r_osym  <= r_trd.sym;
                r_ofreq <= shst_pkg::FREQ_W'(r_trd.freq);
                r_oev   <= 1'b1;
            end else begin
                r_osym  <= '0;
                r_ofreq <= '0;
                r_oev   <= 1'b0;
            end
        end
    end

    assign o_status.t_last   = (r_t == shst_pkg::SYM_W'(shst_pkg::SYMBOL_COUNT - 1));
    assign o_status.s_last   = (r_s == shst_pkg::SYM_W'(shst_pkg::SYMBOL_COUNT - 1));
    assign o_status.i_last   = (shst_pkg::CNT_W'(r_i) == r_n - 1'b1);
    assign o_status.n_zero   = (r_n == '0);
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid      = r_ovalid;
    assign o_symbol         = r_osym;
    assign o_frequency      = r_ofreq;
    assign o_entry_valid    = r_oev;
    assign o_distinct_count = r_odist;

endmodule

// ----- hdl/symbol_histogram_sort_table.sv -----
// Top level of the byte histogram with its sorted, de-duplicated table.
//
//  channel | direction | beat contents
//  i_in    | in        | mode, data_byte, entry_index
//  o_out   | out       | symbol, frequency, entry_valid, distinct_count
//
// A count beat reads, increments and loads the result; a read reads the table first.
// Finalize ranks each symbol by a full scan of the single-port histogram.
// Reset is synchronous and clears the histogram valid bits and table length.
// A new beat is taken once the sequencer is idle and the result register is free.
`timescale 1ns / 1ps
module symbol_histogram_sort_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shst_in_if.sink     i_in,
    shst_out_if.source  o_out
);

    shst_pkg::t_ctrl_cmd  cmd;
    shst_pkg::t_dp_status status;
    logic                 idle, accept;

    assign i_in.ready = idle;
    assign accept     = i_in.valid && idle;

    shst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_in.mode),
        .i_status (status),
        .o_idle   (idle),
        .o_cmd    (cmd)
    );

    shst_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_in.data_byte),
        .i_entry_index    (i_in.entry_index),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_symbol         (o_out.symbol),
        .o_frequency      (o_out.frequency),
        .o_entry_valid    (o_out.entry_valid),
        .o_distinct_count (o_out.distinct_count)
    );

endmodule
